// ===== rtl/slc_pkg.sv =====
package slc_pkg;

	// Field and datapath widths fixed by the item formats.
	localparam int SW  = 24;   // sample, Q1.23
	localparam int GW  = 16;   // preamp gain, Q2.14
	localparam int CW  = 24;   // envelope poles, Q0.24
	localparam int TW  = 24;   // gain table entry, Q12.12
	localparam int IXW = 12;   // table_index field
	localparam int EW  = 32;   // envelopes, Q2.30
	localparam int XW  = 26;   // sample after preamp
	localparam int YW  = 25;   // scaled sample limited to plus or minus one

	// Shared multiplier operand and product widths.
	localparam int MA = 34;
	localparam int MB = 26;
	localparam int MP = MA + MB;

	localparam int TABLE_DEPTH_DEF = 4096;

	// 0.001 in Q0.32.
	localparam logic [22:0] SMOOTH_K = 23'd4294967;

	localparam logic [GW-1:0] PREAMP_RST  = 16'd16384;
	localparam logic [CW-1:0] ATTACK_RST  = 24'd16757717;
	localparam logic [CW-1:0] RELEASE_RST = 24'd16757717;
	localparam logic          SAT_RST     = 1'b1;

	localparam logic CMD_PROCESS = 1'b0;
	localparam logic CMD_TABLE   = 1'b1;

	typedef enum logic [1:0] {
		REG_PREAMP  = 2'd0,
		REG_ATTACK  = 2'd1,
		REG_RELEASE = 2'd2,
		REG_SAT     = 2'd3
	} slc_reg_t;

	typedef struct packed {
		logic [GW-1:0] preamp_gain;
		logic [CW-1:0] attack_coef;
		logic [CW-1:0] release_coef;
		logic          saturate_enable;
	} slc_cfg_t;

	typedef struct packed {
		logic                 command;
		logic signed [SW-1:0] left_sample;
		logic signed [SW-1:0] right_sample;
		logic [IXW-1:0]       table_index;
		logic [TW-1:0]        table_value;
		logic                 last_of_block;
	} slc_item_t;

	typedef struct packed {
		logic signed [SW-1:0] left_out;
		logic signed [SW-1:0] right_out;
		logic                 block_end;
	} slc_res_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_MUL_L,
		S_MUL_R,
		S_PEAK,
		S_PKSEL,
		S_ENV_MUL,
		S_ENV_UPD,
		S_SM_MUL,
		S_SM_UPD,
		S_POS_MUL,
		S_POS,
		S_RD_B,
		S_DIFF,
		S_INT_MUL,
		S_GAIN,
		S_YL_MUL,
		S_YR_MUL,
		S_SQ_L,
		S_SQ_R,
		S_OUT,
		S_DONE
	} slc_state_t;

	// Round half up, then drop sh fraction bits.
	function automatic logic signed [MP-1:0] rnd_shr(input logic signed [MP-1:0] p,
		input int unsigned sh);
		logic signed [MP-1:0] half;
		half = '0;
		half[sh-1] = 1'b1;
		return (p + half) >>> sh;
	endfunction

endpackage

// ===== rtl/slc_mul.sv =====
module slc_mul import slc_pkg::*; (
	input  logic                 clk,
	input  logic signed [MA-1:0] a,
	input  logic signed [MB-1:0] b,
	output logic signed [MP-1:0] p_q
);

	// One signed product per cycle, registered before any use.
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// ===== rtl/slc_core.sv =====
module slc_core import slc_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  slc_cfg_t  cfg,
	input  logic      in_valid,
	output logic      in_ready,
	input  slc_item_t in_item,
	output logic      res_valid,
	input  logic      res_take,
	output slc_res_t  res
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
	localparam logic signed [YW-1:0] Y_ONE = 25'sd8388608;
	localparam logic signed [SW+2:0] OUT_POS = 27'sd8388607;
	localparam logic signed [SW+2:0] OUT_NEG = -27'sd8388608;

	slc_state_t state_q, state_d;

	logic signed [MA-1:0] mul_a;
	logic signed [MB-1:0] mul_b;
	logic signed [MP-1:0] p_q;

	logic signed [SW-1:0] left_q, right_q;
	logic                 last_q;
	logic signed [XW-1:0] xl_q, xr_q;
	logic [EW-1:0]        pk_q, env_q, sm_q;
	logic [AW-1:0]        n_q, rd_addr;
	logic [29:0]          frac_q;
	logic                 clamp_q;
	logic [TW-1:0]        a_q, rdata_q;
	logic signed [TW:0]   diff_q;
	logic [TW-1:0]        m_q;
	logic signed [YW-1:0] yl_q, yr_q;
	logic signed [SW-1:0] outl_q, outr_q;

	logic [TW-1:0] table_mem [TABLE_DEPTH];

	logic           accept, wr_en;
	logic [16:0]    idx_ext;
	logic [29:0]    pos_n;
	logic           pos_clamp;
	logic signed [XW-1:0] neg_l, neg_r;
	logic [XW-2:0]  abs_l, abs_r;

	slc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	function automatic logic [EW-1:0] sat_env(input logic signed [MP-1:0] t);
		if (t < 0) begin
			return '0;
		end else if (t > $signed(MP'(33'h0_FFFF_FFFF))) begin
			return '1;
		end
		return t[EW-1:0];
	endfunction

	function automatic logic signed [YW-1:0] clamp_y(input logic signed [MP-1:0] t);
		if (t > MP'(Y_ONE)) begin
			return Y_ONE;
		end else if (t < -MP'(Y_ONE)) begin
			return -Y_ONE;
		end
		return t[YW-1:0];
	endfunction

	// Soft curve 2y -+ y*y on a value already limited to plus or minus one,
	// or the plain value for hard clip; +1.0 maps to full scale.
	function automatic logic signed [SW-1:0] shape(input logic signed [YW-1:0] y,
		input logic signed [MP-1:0] prod, input logic sat_en);
		logic signed [MP-1:0]   sq;
		logic signed [SW+2:0]   y2, r;
		sq = rnd_shr(prod, 23);
		y2 = (SW+3)'(y) <<< 1;
		if (!sat_en) begin
			r = (SW+3)'(y);
		end else if (y > 0) begin
			r = y2 - sq[SW+2:0];
		end else begin
			r = y2 + sq[SW+2:0];
		end
		if (r > OUT_POS) begin
			r = OUT_POS;
		end else if (r < OUT_NEG) begin
			r = OUT_NEG;
		end
		return r[SW-1:0];
	endfunction

	assign accept  = in_valid && in_ready;
	assign idx_ext = 17'(in_item.table_index);
	assign wr_en   = accept && (in_item.command == CMD_TABLE) &&
	                 (idx_ext < 17'(TABLE_DEPTH));

	assign pos_n     = p_q[59:30];
	assign pos_clamp = pos_n >= 30'(TABLE_DEPTH - 1);
	assign neg_l     = -xl_q;
	assign neg_r     = -xr_q;
	assign abs_l     = xl_q[XW-1] ? neg_l[XW-2:0] : xl_q[XW-2:0];
	assign abs_r     = xr_q[XW-1] ? neg_r[XW-2:0] : xr_q[XW-2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		rd_addr   = n_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_item.command == CMD_PROCESS) begin
					state_d = S_MUL_L;
				end
			end
			S_MUL_L: begin
				mul_a   = MA'(left_q);
				mul_b   = MB'(cfg.preamp_gain);
				state_d = S_MUL_R;
			end
			S_MUL_R: begin
				mul_a   = MA'(right_q);
				mul_b   = MB'(cfg.preamp_gain);
				state_d = S_PEAK;
			end
			S_PEAK:  state_d = S_PKSEL;
			S_PKSEL: state_d = S_ENV_MUL;
			S_ENV_MUL: begin
				mul_a   = MA'(env_q) - MA'(pk_q);
				mul_b   = (env_q < pk_q) ? MB'(cfg.attack_coef) : MB'(cfg.release_coef);
				state_d = S_ENV_UPD;
			end
			S_ENV_UPD: state_d = S_SM_MUL;
			S_SM_MUL: begin
				mul_a   = MA'(env_q) - MA'(sm_q);
				mul_b   = MB'(SMOOTH_K);
				state_d = S_SM_UPD;
			end
			S_SM_UPD: state_d = S_POS_MUL;
			S_POS_MUL: begin
				mul_a   = MA'(sm_q);
				mul_b   = MB'(TABLE_DEPTH - 1);
				state_d = S_POS;
			end
			S_POS: begin
				rd_addr = pos_clamp ? LAST_ADDR : pos_n[AW-1:0];
				state_d = S_RD_B;
			end
			S_RD_B: begin
				rd_addr = n_q + AW'(1);
				state_d = S_DIFF;
			end
			S_DIFF: state_d = S_INT_MUL;
			S_INT_MUL: begin
				mul_a   = MA'(frac_q);
				mul_b   = MB'(diff_q);
				state_d = S_GAIN;
			end
			S_GAIN: state_d = S_YL_MUL;
			S_YL_MUL: begin
				mul_a   = MA'(xl_q);
				mul_b   = MB'(m_q);
				state_d = S_YR_MUL;
			end
			S_YR_MUL: begin
				mul_a   = MA'(xr_q);
				mul_b   = MB'(m_q);
				state_d = S_SQ_L;
			end
			S_SQ_L: begin
				mul_a   = MA'(yl_q);
				mul_b   = MB'(yl_q);
				state_d = S_SQ_R;
			end
			S_SQ_R: begin
				mul_a   = MA'(yr_q);
				mul_b   = MB'(yr_q);
				state_d = S_OUT;
			end
			S_OUT: state_d = S_DONE;
			S_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Envelope state survives between items and clears on reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q <= '0;
			sm_q  <= '0;
		end else begin
			if (state_q == S_ENV_UPD) begin
				env_q <= sat_env($signed(MP'(pk_q)) + rnd_shr(p_q, 24));
			end
			if (state_q == S_SM_UPD) begin
				sm_q <= sat_env($signed(MP'(sm_q)) + rnd_shr(p_q, 32));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			left_q  <= in_item.left_sample;
			right_q <= in_item.right_sample;
			last_q  <= in_item.last_of_block;
		end
		unique case (state_q)
			S_MUL_R: xl_q <= XW'(rnd_shr(p_q, 14));
			S_PEAK:  xr_q <= XW'(rnd_shr(p_q, 14));
			S_PKSEL: pk_q <= {((abs_l > abs_r) ? abs_l : abs_r), 7'b0};
			S_POS: begin
				n_q     <= pos_clamp ? LAST_ADDR : pos_n[AW-1:0];
				frac_q  <= p_q[29:0];
				clamp_q <= pos_clamp;
			end
			S_RD_B:  a_q    <= rdata_q;
			S_DIFF:  diff_q <= $signed({1'b0, rdata_q}) - $signed({1'b0, a_q});
			S_GAIN: begin
				if (clamp_q) begin
					m_q <= a_q;
				end else begin
					m_q <= TW'($signed(MP'(a_q)) + rnd_shr(p_q, 30));
				end
			end
			S_YR_MUL: yl_q   <= clamp_y(rnd_shr(p_q, 12));
			S_SQ_L:   yr_q   <= clamp_y(rnd_shr(p_q, 12));
			S_SQ_R:   outl_q <= shape(yl_q, p_q, cfg.saturate_enable);
			S_OUT:    outr_q <= shape(yr_q, p_q, cfg.saturate_enable);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[idx_ext[AW-1:0]] <= in_item.table_value;
		end
		rdata_q <= table_mem[rd_addr];
	end

	assign res.left_out  = outl_q;
	assign res.right_out = outr_q;
	assign res.block_end = last_q;

endmodule

// ===== rtl/stereo_lut_compressor_unit.sv =====
// Channel   Dir  Signals                            Contents
// s_*       in   tvalid tready tdata[87:0] tuser tlast   sample pair or table write
// m_*       out  tvalid tready tdata[47:0] tlast         processed sample pair
// APB       in   psel penable pwrite paddr[3:0] pwdata prdata pready   registers
//
// A table write beat is absorbed in the cycle it is accepted and leaves
// s_tready high. A sample pair beat keeps s_tready low until it is through:
// 19 sequencer steps around the one shared 34x26 multiplier and its table
// reads, a done state that hands the result to the output register, and
// the idle state in which the next beat is accepted.
// The output register lets the core move on while a result waits on m_tready;
// a second result stalls in the core until the first beat is taken.
// arst_n clears the registers, both envelopes and all handshake state; the
// gain table is not cleared and must be loaded before it is used.
module stereo_lut_compressor_unit import slc_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Sample and table input.
	input  logic        s_tvalid,
	output logic        s_tready,
	// [23:0] left_sample, [47:24] right_sample, [59:48] table_index,
	// [83:60] table_value, [87:84] zero
	input  logic [87:0] s_tdata,
	// [0] command
	input  logic        s_tuser,
	input  logic        s_tlast,
	// Processed output.
	output logic        m_tvalid,
	input  logic        m_tready,
	// [23:0] left_out, [47:24] right_out
	output logic [47:0] m_tdata,
	output logic        m_tlast,
	// Register port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	slc_cfg_t  cfg_q;
	slc_item_t item;
	slc_res_t  res;
	logic      res_valid, res_take;
	logic      m_tvalid_q;
	logic [47:0] m_tdata_q;
	logic      m_tlast_q;
	slc_reg_t  reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = slc_reg_t'(paddr[3:2]);

	// Registers are written in the access phase; the port never waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.preamp_gain     <= PREAMP_RST;
			cfg_q.attack_coef     <= ATTACK_RST;
			cfg_q.release_coef    <= RELEASE_RST;
			cfg_q.saturate_enable <= SAT_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_PREAMP:  cfg_q.preamp_gain     <= pwdata[GW-1:0];
				REG_ATTACK:  cfg_q.attack_coef     <= pwdata[CW-1:0];
				REG_RELEASE: cfg_q.release_coef    <= pwdata[CW-1:0];
				REG_SAT:     cfg_q.saturate_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_PREAMP:  prdata = 32'(cfg_q.preamp_gain);
			REG_ATTACK:  prdata = 32'(cfg_q.attack_coef);
			REG_RELEASE: prdata = 32'(cfg_q.release_coef);
			REG_SAT:     prdata = 32'(cfg_q.saturate_enable);
			default:     prdata = '0;
		endcase
	end

	assign item.command       = s_tuser;
	assign item.left_sample   = s_tdata[23:0];
	assign item.right_sample  = s_tdata[47:24];
	assign item.table_index   = s_tdata[59:48];
	assign item.table_value   = s_tdata[83:60];
	assign item.last_of_block = s_tlast;

	slc_core #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (item),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	// The output register is loaded whenever it is empty or being drained.
	assign res_take = res_valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			m_tdata_q <= {res.right_out, res.left_out};
			m_tlast_q <= res.block_end;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== rtl/slc_checker.sv =====
module slc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tlast
);

	// A waiting output beat holds still.
	property p_out_hold;
		@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast);
	endproperty
	a_out_hold: assert property (p_out_hold)
		else $error("output beat changed while stalled");

	// Accepting a sample pair closes the input.
	property p_busy_after_pair;
		@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser |=> !s_tready;
	endproperty
	a_busy_after_pair: assert property (p_busy_after_pair)
		else $error("input reopened right after a sample pair");

	// A table write is absorbed at once.
	property p_table_write_free;
		@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> s_tready;
	endproperty
	a_table_write_free: assert property (p_table_write_free)
		else $error("table write held the input closed");

	// A result only appears at the end of a busy stretch.
	property p_result_after_busy;
		@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready) && !$past(s_tready, 2);
	endproperty
	a_result_after_busy: assert property (p_result_after_busy)
		else $error("result appeared without a sample pair in work");

endmodule

bind stereo_lut_compressor_unit slc_checker u_slc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
